@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BNH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define BNH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bnh_pkg.sv @@
`default_nettype none

package bnh_pkg;

  // Default word limit per number
  localparam int MAX_WORDS_DEF = 4096;

  // Field widths of the result beat
  localparam int BIT_LENGTH_W = 19;
  localparam int EFF_WORDS_W  = 13;
  localparam int WORD_W       = 64;

  // Hash seed
  localparam logic [WORD_W-1:0] HASH_SEED = 64'h0123_4567_89ab_cdef;

  // Input beat
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [BIT_LENGTH_W-1:0] bit_length;
    logic [EFF_WORDS_W-1:0]  effective_words;
    logic [WORD_W-1:0]       hash;
    logic                    is_zero;
    logic                    is_one;
    logic                    is_even;
    logic                    is_pow2;
  } out_beat_t;

endpackage

`default_nettype wire

@@ rtl/bnh_tracker.sv @@
`default_nettype none
`include "assert_macros.svh"

// Per-number state: running hash, top nonzero word info and flags.
// Updates on each advancing beat and returns to its reset state after a last word.
module bnh_tracker #(
  parameter int MAX_WORDS = bnh_pkg::MAX_WORDS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire bnh_pkg::in_beat_t beat,
  output bnh_pkg::out_beat_t     result
);

  localparam int IW  = $clog2(MAX_WORDS + 1);
  localparam int BLW = IW + 7;
  localparam logic [IW-1:0] MAXW = IW'(MAX_WORDS);

  // Number of significant bits in a word
  function automatic logic [6:0] bits_in_word(logic [bnh_pkg::WORD_W-1:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < bnh_pkg::WORD_W; i++) begin
      if (v[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

  logic [bnh_pkg::WORD_W-1:0] rh_r, rh_nxt, rh_eff;
  logic [bnh_pkg::WORD_W-1:0] hat_r, hat_nxt, hat_eff;
  logic [IW-1:0]              idx_r, idx_nxt, idx_eff;
  logic [IW-1:0]              ti_r, ti_nxt, ti_eff;
  logic [6:0]                 tbits_r, tbits_nxt, tbits_eff;
  logic                       tone_r, tone_nxt, tone_eff;
  logic                       tpow_r, tpow_nxt, tpow_eff;
  logic                       nz_r, nz_nxt, nz_eff;
  logic                       sev_r, sev_nxt, sev_eff;
  logic                       odd_r, odd_nxt, odd_eff;

  logic [bnh_pkg::WORD_W-1:0] rh_upd;
  logic [IW-1:0]              ti_m1;
  logic [BLW-1:0]             blen_full;

  assign rh_upd = {rh_r[bnh_pkg::WORD_W-4:0], rh_r[bnh_pkg::WORD_W-1:bnh_pkg::WORD_W-3]}
                  ^ beat.word;

  // Fold in the current word, unless the word limit is reached
  always_comb begin
    rh_eff    = rh_r;
    hat_eff   = hat_r;
    idx_eff   = idx_r;
    ti_eff    = ti_r;
    tbits_eff = tbits_r;
    tone_eff  = tone_r;
    tpow_eff  = tpow_r;
    nz_eff    = nz_r;
    sev_eff   = sev_r;
    odd_eff   = odd_r;
    if (idx_r < MAXW) begin
      rh_eff = rh_upd;
      if (idx_r == '0) odd_eff = beat.word[0];
      if (beat.word != '0) begin
        sev_eff   = sev_r | nz_r;
        nz_eff    = 1'b1;
        ti_eff    = idx_r + IW'(1);
        tbits_eff = bits_in_word(beat.word);
        tone_eff  = (beat.word == bnh_pkg::WORD_W'(1));
        tpow_eff  = ((beat.word & (beat.word - bnh_pkg::WORD_W'(1))) == '0);
        hat_eff   = rh_upd;
      end
      idx_eff = idx_r + IW'(1);
    end
  end

  // Result from the folded state
  assign ti_m1     = ti_eff - IW'(1);
  assign blen_full = BLW'({ti_m1, 6'b0}) + BLW'(tbits_eff);

  always_comb begin
    if (!nz_eff) begin
      result.bit_length      = '0;
      result.effective_words = '0;
      result.hash            = '0;
      result.is_zero         = 1'b1;
      result.is_one          = 1'b0;
      result.is_even         = 1'b1;
      result.is_pow2         = 1'b0;
    end else begin
      result.bit_length      = bnh_pkg::BIT_LENGTH_W'(blen_full);
      result.effective_words = bnh_pkg::EFF_WORDS_W'(ti_eff);
      result.hash            = hat_eff;
      result.is_zero         = 1'b0;
      result.is_one          = (ti_eff == IW'(1)) && tone_eff;
      result.is_even         = !odd_eff;
      result.is_pow2         = !sev_eff && tpow_eff;
    end
  end

  // Next state: folded values, or back to reset after the last word
  always_comb begin
    rh_nxt    = rh_eff;
    hat_nxt   = hat_eff;
    idx_nxt   = idx_eff;
    ti_nxt    = ti_eff;
    tbits_nxt = tbits_eff;
    tone_nxt  = tone_eff;
    tpow_nxt  = tpow_eff;
    nz_nxt    = nz_eff;
    sev_nxt   = sev_eff;
    odd_nxt   = odd_eff;
    if (beat.last) begin
      rh_nxt    = bnh_pkg::HASH_SEED;
      hat_nxt   = '0;
      idx_nxt   = '0;
      ti_nxt    = '0;
      tbits_nxt = '0;
      tone_nxt  = 1'b0;
      tpow_nxt  = 1'b0;
      nz_nxt    = 1'b0;
      sev_nxt   = 1'b0;
      odd_nxt   = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rh_r    <= bnh_pkg::HASH_SEED;
      hat_r   <= '0;
      idx_r   <= '0;
      ti_r    <= '0;
      tbits_r <= '0;
      tone_r  <= 1'b0;
      tpow_r  <= 1'b0;
      nz_r    <= 1'b0;
      sev_r   <= 1'b0;
      odd_r   <= 1'b0;
    end else if (adv) begin
      rh_r    <= rh_nxt;
      hat_r   <= hat_nxt;
      idx_r   <= idx_nxt;
      ti_r    <= ti_nxt;
      tbits_r <= tbits_nxt;
      tone_r  <= tone_nxt;
      tpow_r  <= tpow_nxt;
      nz_r    <= nz_nxt;
      sev_r   <= sev_nxt;
      odd_r   <= odd_nxt;
    end
  end

  `BNH_ASSERT_IMPL(a_idx_bound, clk, rst_n, 1'b1, idx_r <= MAXW && ti_r <= idx_r,
                   "word index out of range")
  `BNH_ASSERT_IMPL(a_top_tracked, clk, rst_n, nz_r, ti_r != '0 && tbits_r != '0,
                   "top word tracking lost")
  `BNH_ASSERT_NEXT(a_last_clears, clk, rst_n, adv && beat.last,
                   idx_r == '0 && !nz_r && rh_r == bnh_pkg::HASH_SEED,
                   "state not cleared after last word")

endmodule

`default_nettype wire

@@ rtl/bignum_normalize_and_hash.sv @@
// A last word is held in the input register, then its result in the result register on out_*.
// Throughput: one word per cycle while no last word is held; set by the single rotate-xor and flag update per word.
// Non-last words keep flowing while a result waits; a last word holds until the result
// register frees. Reset (rst_n low, synchronous) empties both registers and reloads the
// hash seed and cleared tracking state; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module bignum_normalize_and_hash #(
  parameter int MAX_WORDS = bnh_pkg::MAX_WORDS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire bnh_pkg::in_beat_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output bnh_pkg::out_beat_t     out_data
);

  logic               s1_valid_r, s1_valid_nxt;
  bnh_pkg::in_beat_t  s1_data_r;
  logic               out_valid_r, out_valid_nxt;
  bnh_pkg::out_beat_t out_data_r;
  bnh_pkg::out_beat_t result;

  logic s1_move;
  logic s1_adv;
  logic in_take;
  logic out_load;

  // A non-last word always moves; a last word needs room in the result register
  assign s1_move  = !s1_data_r.last || !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && s1_move;
  assign in_stall = s1_valid_r && !s1_move;
  assign in_take  = in_valid && !in_stall;
  assign out_load = s1_adv && s1_data_r.last;

  bnh_tracker #(
    .MAX_WORDS(MAX_WORDS)
  ) u_tracker (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (s1_adv),
    .beat  (s1_data_r),
    .result(result)
  );

  // Input register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) s1_valid_nxt = 1'b1;
    else if (s1_move) s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_data_r <= in_data;
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BNH_ASSERT_IMPL(a_stall_only_last, clk, rst_n, in_stall,
                   s1_valid_r && s1_data_r.last && out_valid_r && out_stall,
                   "input stalled without a blocked last word")
  `BNH_ASSERT_IMPL(a_zero_result, clk, rst_n, out_valid_r && out_data_r.is_zero,
                   out_data_r.hash == '0 && out_data_r.bit_length == '0 &&
                   out_data_r.effective_words == '0,
                   "zero result carries nonzero fields")
  `BNH_ASSERT_NEXT(a_last_loads, clk, rst_n, out_load,
                   out_valid_r, "last word did not produce a result")

endmodule

`default_nettype wire

@@ tb/sv/bnh_result_checker.sv @@
`timescale 1ns / 1ps

module bnh_result_checker #(
  parameter int MAX_WORDS = bnh_pkg::MAX_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  bnh_pkg::in_beat_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  bnh_pkg::out_beat_t out_data,
  output int                 fail_count,
  output int                 pending
);
  import bnh_pkg::*;

  // tracking state for the number currently streaming in
  logic [WORD_W-1:0] run_hash;
  logic [WORD_W-1:0] hash_at_msw;
  int                words_taken;
  int                msw_pos;
  logic [WORD_W-1:0] msw_val;
  logic              any_nonzero;
  logic              multi_nonzero;
  logic              low_odd;

  // predicted normal forms, oldest first
  out_beat_t norm_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic restart_number();
    run_hash      = HASH_SEED;
    hash_at_msw   = '0;
    words_taken   = 0;
    msw_pos       = 0;
    msw_val       = '0;
    any_nonzero   = 1'b0;
    multi_nonzero = 1'b0;
    low_odd       = 1'b0;
  endtask

  // normal form of the number just closed
  function automatic out_beat_t summarize();
    out_beat_t r;
    int        msb;
    r = '0;
    if (!any_nonzero) begin
      r.is_zero = 1'b1;
      r.is_even = 1'b1;
    end else begin
      msb = WORD_W;
      while (!msw_val[msb-1]) msb--;
      r.bit_length      = BIT_LENGTH_W'((msw_pos - 1) * WORD_W + msb);
      r.effective_words = EFF_WORDS_W'(msw_pos);
      r.hash            = hash_at_msw;
      r.is_one          = (msw_pos == 1) && (msw_val == 64'd1);
      r.is_even         = !low_odd;
      r.is_pow2         = !multi_nonzero && ((msw_val & (msw_val - 64'd1)) == '0);
    end
    return r;
  endfunction

  // words past the limit are dropped; a last mark among them still closes the number
  task automatic take_word(input in_beat_t b);
    if (words_taken < MAX_WORDS) begin
      run_hash = {run_hash[WORD_W-4:0], run_hash[WORD_W-1:WORD_W-3]} ^ b.word;
      if (words_taken == 0) low_odd = b.word[0];
      if (b.word != '0) begin
        if (any_nonzero) multi_nonzero = 1'b1;
        any_nonzero = 1'b1;
        msw_pos     = words_taken + 1;
        msw_val     = b.word;
        hash_at_msw = run_hash;
      end
      words_taken++;
    end
    if (b.last) begin
      norm_q.push_back(summarize());
      restart_number();
    end
  endtask

  task automatic flag_mismatch(input string msg);
    fail_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic compare_norm(input out_beat_t got, input out_beat_t want);
    if (got.bit_length !== want.bit_length)
      flag_mismatch($sformatf("bit_length got %0d want %0d",
                              got.bit_length, want.bit_length));
    if (got.effective_words !== want.effective_words)
      flag_mismatch($sformatf("effective_words got %0d want %0d",
                              got.effective_words, want.effective_words));
    if (got.hash !== want.hash)
      flag_mismatch($sformatf("hash got 0x%h want 0x%h", got.hash, want.hash));
    if (got.is_zero !== want.is_zero)
      flag_mismatch($sformatf("is_zero got %b want %b", got.is_zero, want.is_zero));
    if (got.is_one !== want.is_one)
      flag_mismatch($sformatf("is_one got %b want %b", got.is_one, want.is_one));
    if (got.is_even !== want.is_even)
      flag_mismatch($sformatf("is_even got %b want %b", got.is_even, want.is_even));
    if (got.is_pow2 !== want.is_pow2)
      flag_mismatch($sformatf("is_pow2 got %b want %b",
                              got.is_pow2, want.is_pow2));
  endtask

  // result beats are checked before the word of the same edge is absorbed
  always @(posedge clk) begin
    if (!rst_n) begin
      restart_number();
      norm_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (norm_q.size() == 0)
          flag_mismatch($sformatf("result beat 0x%h with none expected", out_data));
        else
          compare_norm(out_data, norm_q.pop_front());
      end
      if (in_valid && !in_stall) take_word(in_data);
    end
    pending <= norm_q.size();
  end

endmodule

@@ tb/sv/bignum_normalize_and_hash_tb.sv @@
`timescale 1ns / 1ps

module bignum_normalize_and_hash_tb;
  import bnh_pkg::*;

  localparam int MAX_WORDS = MAX_WORDS_DEF;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int words_sent = 0;

  bignum_normalize_and_hash #(
    .MAX_WORDS(MAX_WORDS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  bnh_result_checker #(
    .MAX_WORDS(MAX_WORDS)
  ) i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("FAIL bignum_normalize_and_hash");
    $finish;
  end

  // receiver back-pressure
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // one beat, with a random idle gap ahead of it
  task automatic send_word(input logic [WORD_W-1:0] w, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data.word <= w;
    in_data.last <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // word values biased toward the corners
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 64'd1;
      2:       return 64'd1 << $urandom_range(WORD_W - 1);
      3:       return '1;
      4:       return {$urandom, $urandom} >> $urandom_range(WORD_W - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // one number: trailing zeros, a lone nonzero word, all zero, or dense
  task automatic send_number(input int n_words);
    int                shape;
    int                cut;
    int                hot;
    logic [WORD_W-1:0] w;
    shape = $urandom_range(9);
    cut   = $urandom_range(1, n_words);
    hot   = $urandom_range(0, n_words - 1);
    for (int i = 0; i < n_words; i++) begin
      case (shape)
        0, 1, 2: w = (i < cut) ? pick_word() : '0;
        3, 4:    w = (i == hot) ? pick_word() : '0;
        5:       w = '0;
        default: w = pick_word();
      endcase
      send_word(w, i == n_words - 1);
    end
  endtask

  task automatic random_phase(input int idle_pct, input int stall_pct, input int budget);
    int stop_at;
    send_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    stop_at = words_sent + budget;
    while (words_sent < stop_at) begin
      if ($urandom_range(9) == 0)
        send_number($urandom_range(9, 40));
      else
        send_number($urandom_range(1, 4));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners under the first idling pattern
    send_idle_pct = 35;
    recv_stall_pct <= 78;
    send_word('0, 1'b1);
    send_word(64'd1, 1'b1);
    send_word('1, 1'b1);
    send_word(64'h8000_0000_0000_0000, 1'b1);
    send_word(64'd2, 1'b1);
    // power of two above the lowest word
    send_word('0, 1'b0);
    send_word(64'd1, 1'b1);
    // trailing zero words drop out
    send_word(64'd3, 1'b0);
    send_word('0, 1'b0);
    send_word('0, 1'b1);
    // two single-bit words: not a power of two
    send_word(64'd1, 1'b0);
    send_word(64'd1, 1'b1);
    // multiword zero
    send_word('0, 1'b0);
    send_word('0, 1'b0);
    send_word('0, 1'b1);
    // odd low word under a full top word
    send_word(64'hffff, 1'b0);
    send_word('0, 1'b0);
    send_word(64'h8000_0000_0000_0000, 1'b1);
    send_word('1, 1'b0);
    send_word('1, 1'b1);

    random_phase(35, 78, 600);
    random_phase(78, 35, 600);
    random_phase(0, 0, 500);

    // drain outstanding results
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("PASS bignum_normalize_and_hash");
    else
      $display("FAIL bignum_normalize_and_hash");
    $finish;
  end

endmodule
